FILE: rtl/csw_pkg.sv
package csw_pkg;

  localparam int MAX_LENGTH   = 4096;
  localparam int FRAC_BITS    = 16;
  localparam int IDX_W        = 12;
  localparam int LEN_W        = 13;
  localparam int TYPE_W       = 3;
  localparam int DEN_W        = 14;
  localparam int BASE_W       = 13;
  localparam int OUT_W        = FRAC_BITS + 3;
  localparam int Q_W          = 30;
  localparam int T_W          = 31;
  localparam int COS_W        = 32;
  localparam int PROD_W       = 64;
  localparam int ACC_W        = 67;
  localparam int ROUND_SHIFT  = 60 - FRAC_BITS;
  localparam int NUM_TERMS    = 8;
  localparam int NUM_TYPES    = 6;
  localparam int DIV_STEP     = 2;
  localparam int DIV_STAGES   = Q_W / DIV_STEP;
  localparam int SERIES_STEPS = 6;
  localparam int LANE_LAT     = 3 + DIV_STAGES + 2 + 3 * SERIES_STEPS + 2;

  localparam logic [Q_W-1:0] PI4   = 30'd843314857;
  localparam logic [T_W-1:0] T_ONE = 31'h40000000;

  localparam logic [TYPE_W-1:0] TYPE_GAUSS = 3'd5;

  localparam logic [7:0] COS_DIV [SERIES_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [7:0] SIN_DIV [SERIES_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

  // floor(2^32 / d) for each series divisor
  localparam logic [31:0] COS_RECIP [SERIES_STEPS] = '{
    32'd32537631, 32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648};
  localparam logic [31:0] SIN_RECIP [SERIES_STEPS] = '{
    32'd27531841, 32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882};

  localparam logic signed [COS_W-1:0] COEF_TAB [NUM_TYPES][NUM_TERMS] = '{
    '{32'sd1745768471, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd1073741824, -32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd1187116183, -32'sd1011247119, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd942202349, -32'sd1121669463, 32'sd179467114, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
      32'sd0},
    '{32'sd814990993, -32'sd1109273735, 32'sd320953112, -32'sd26534062, 32'sd0, 32'sd0,
      32'sd0, 32'sd0},
    '{32'sd592339792, -32'sd966877045, 32'sd525598051, -32'sd190339619, 32'sd45909912,
      -32'sd7377050, 32'sd788768, -32'sd42810}
  };

  function automatic logic [7:0] ser_div(input logic use_sin, input logic [2:0] j);
    return use_sin ? SIN_DIV[j] : COS_DIV[j];
  endfunction

  function automatic logic [31:0] ser_recip(input logic use_sin, input logic [2:0] j);
    return use_sin ? SIN_RECIP[j] : COS_RECIP[j];
  endfunction

endpackage

FILE: rtl/csw_lane.sv
module csw_lane import csw_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [2:0]              k,
  input  logic [DEN_W-1:0]        den,
  input  logic [BASE_W-1:0]       base,
  output logic signed [COS_W-1:0] cos_value
);

  typedef struct packed {
    logic [Q_W-1:0] x2;
    logic [Q_W-1:0] x;
    logic           use_sin;
    logic           neg;
  } ser_ctx_t;

  // phase reduction
  logic [DEN_W-1:0] m;
  logic [DEN_W-1:0] r;
  logic [2:0]       oct;
  logic [DEN_W-1:0] m_next;
  logic [DEN_W-1:0] r_next;
  logic [2:0]       oct_next;

  always_comb begin
    logic [16:0] kb;
    logic [16:0] m8;
    kb = 17'(k) * 17'(base);
    if (kb >= (17'(den) << 2)) kb = kb - (17'(den) << 2);
    if (kb >= (17'(den) << 1)) kb = kb - (17'(den) << 1);
    if (kb >= 17'(den)) kb = kb - 17'(den);
    m_next = kb[DEN_W-1:0];
    m8 = {m, 3'b000};
    oct_next = '0;
    if (m8 >= (17'(den) << 2)) begin
      m8 = m8 - (17'(den) << 2);
      oct_next[2] = 1'b1;
    end
    if (m8 >= (17'(den) << 1)) begin
      m8 = m8 - (17'(den) << 1);
      oct_next[1] = 1'b1;
    end
    if (m8 >= 17'(den)) begin
      m8 = m8 - 17'(den);
      oct_next[0] = 1'b1;
    end
    r_next = m8[DEN_W-1:0];
  end

  // long division of r*pi/4 by den, two quotient bits a stage
  logic [DEN_W-1:0] dv_rem [DIV_STAGES+1];
  logic [Q_W-1:0]   dv_low [DIV_STAGES+1];
  logic [Q_W-1:0]   dv_q   [DIV_STAGES+1];
  logic [2:0]       dv_oct [DIV_STAGES+1];
  logic [DEN_W-1:0] dn_rem [DIV_STAGES];
  logic [Q_W-1:0]   dn_low [DIV_STAGES];
  logic [Q_W-1:0]   dn_q   [DIV_STAGES];
  logic [43:0]      a;

  assign a = 44'(r) * 44'(PI4);

  always_comb begin
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   low;
    logic [Q_W-1:0]   q;
    for (int g = 0; g < DIV_STAGES; g++) begin
      rem = dv_rem[g];
      low = dv_low[g];
      q   = dv_q[g];
      for (int j = 0; j < DIV_STEP; j++) begin
        trial = {rem, low[Q_W-1]};
        low   = {low[Q_W-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          trial = trial - {1'b0, den};
          q     = {q[Q_W-2:0], 1'b1};
        end else begin
          q     = {q[Q_W-2:0], 1'b0};
        end
        rem = trial[DEN_W-1:0];
      end
      dn_rem[g] = rem;
      dn_low[g] = low;
      dn_q[g]   = q;
    end
  end

  // angle select: th, or its complement for odd octants
  logic [Q_W-1:0] th;
  logic [Q_W-1:0] thc;
  logic [2:0]     oct_d;
  logic [Q_W-1:0] x;
  logic           use_sin;
  logic           neg;
  logic [59:0]    xx;

  assign th    = dv_q[DIV_STAGES];
  assign oct_d = dv_oct[DIV_STAGES];
  assign thc   = PI4 - th - Q_W'(dv_rem[DIV_STAGES] != '0);
  assign xx    = 60'(x) * 60'(x);

  // Taylor series, three stages a step
  ser_ctx_t       ss_ctx  [SERIES_STEPS+1];
  logic [T_W-1:0] ss_t    [SERIES_STEPS+1];
  ser_ctx_t       sa_ctx  [SERIES_STEPS];
  logic [60:0]    sa_prod [SERIES_STEPS];
  ser_ctx_t       sb_ctx  [SERIES_STEPS];
  logic [T_W-1:0] sb_p    [SERIES_STEPS];
  logic [62:0]    sb_pm   [SERIES_STEPS];
  logic [60:0]    prod_c  [SERIES_STEPS];
  logic [62:0]    pm_c    [SERIES_STEPS];
  logic [T_W-1:0] tn_c    [SERIES_STEPS];

  always_comb begin
    logic [T_W-1:0] qe;
    logic [T_W-1:0] rem;
    logic [T_W-1:0] d;
    for (int j = 0; j < SERIES_STEPS; j++) begin
      prod_c[j] = 61'(ss_ctx[j].x2) * 61'(ss_t[j]);
      pm_c[j]   = 63'(sa_prod[j][60:30]) * 63'(ser_recip(sa_ctx[j].use_sin, 3'(j)));
      d   = T_W'(ser_div(sb_ctx[j].use_sin, 3'(j)));
      qe  = sb_pm[j][62:32];
      rem = sb_p[j] - T_W'(qe * d);
      if (rem >= d) qe = qe + 1'b1;
      tn_c[j] = T_ONE - qe;
    end
  end

  logic [60:0]    sp;
  logic [T_W-1:0] fin_res;
  logic           fin_neg;

  assign sp = 61'(ss_ctx[SERIES_STEPS].x) * 61'(ss_t[SERIES_STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      m         <= m_next;
      r         <= r_next;
      oct       <= oct_next;
      dv_rem[0] <= a[43:30];
      dv_low[0] <= a[29:0];
      dv_q[0]   <= '0;
      dv_oct[0] <= oct;
      for (int g = 0; g < DIV_STAGES; g++) begin
        dv_rem[g+1] <= dn_rem[g];
        dv_low[g+1] <= dn_low[g];
        dv_q[g+1]   <= dn_q[g];
        dv_oct[g+1] <= dv_oct[g];
      end
      x       <= oct_d[0] ? thc : th;
      use_sin <= oct_d[0] ^ oct_d[1];
      neg     <= oct_d[1] ^ oct_d[2];
      ss_ctx[0] <= '{x2: xx[59:30], x: x, use_sin: use_sin, neg: neg};
      ss_t[0]   <= T_ONE;
      for (int j = 0; j < SERIES_STEPS; j++) begin
        sa_ctx[j]   <= ss_ctx[j];
        sa_prod[j]  <= prod_c[j];
        sb_ctx[j]   <= sa_ctx[j];
        sb_p[j]     <= sa_prod[j][60:30];
        sb_pm[j]    <= pm_c[j];
        ss_ctx[j+1] <= sb_ctx[j];
        ss_t[j+1]   <= tn_c[j];
      end
      fin_res   <= ss_ctx[SERIES_STEPS].use_sin ? sp[60:30] : ss_t[SERIES_STEPS];
      fin_neg   <= ss_ctx[SERIES_STEPS].neg;
      cos_value <= fin_neg ? -$signed({1'b0, fin_res}) : $signed({1'b0, fin_res});
    end
  end

endmodule

FILE: rtl/cosine_sum_window_generator.sv
// Cosine-sum window generator.
// Each index passes the base register, the 40-stage cosine lanes (phase
// reduction, 15-stage divider, 18-stage series), the weights and the sum tree.
// Throughput: one index per cycle; a stall at the output holds the whole pipe.
// Reset (rst, synchronous): window type Gaussian, length 256, pipe emptied.
module cosine_sum_window_generator import csw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  logic [IDX_W-1:0]        sample_index,
  output logic                    window_valid,
  input  logic                    window_stall,
  output logic signed [OUT_W-1:0] window_value,
  output logic                    index_error,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic REG_WINDOW_TYPE   = 1'b0;
  localparam logic REG_WINDOW_LENGTH = 1'b1;
  localparam int   VP_LEN            = LANE_LAT + 5;

  // configuration registers
  logic [TYPE_W-1:0] wtype;
  logic [LEN_W-1:0]  wlen;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wtype <= TYPE_GAUSS;
      wlen  <= LEN_W'(256);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_WINDOW_TYPE:   wtype <= pwdata[TYPE_W-1:0];
        REG_WINDOW_LENGTH: wlen  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WINDOW_TYPE:   prdata = 32'(wtype);
      REG_WINDOW_LENGTH: prdata = 32'(wlen);
      default:           prdata = '0;
    endcase
  end

  // Clamp type, length; user keeps both fixed with items in flight, unchecked.
  logic [TYPE_W-1:0] type_eff;
  logic [LEN_W-1:0]  n_eff;
  logic [DEN_W-1:0]  den;

  assign type_eff = (wtype > TYPE_GAUSS) ? TYPE_GAUSS : wtype;
  assign n_eff    = (wlen > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : wlen;
  assign den      = {n_eff, 1'b0};

  // Advance every stage unless a finished result is held by the output stall.
  logic en;
  assign en           = !window_valid || !window_stall;
  assign sample_stall = !en;

  logic              vp [VP_LEN];
  logic              ep [VP_LEN];
  logic [BASE_W-1:0] base;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < VP_LEN; s++) vp[s] <= 1'b0;
      window_valid <= 1'b0;
    end else if (en) begin
      vp[0] <= sample_valid;
      for (int s = 1; s < VP_LEN; s++) vp[s] <= vp[s-1];
      window_valid <= vp[VP_LEN-1];
    end
  end

  // One lane per cosine term; term k runs at k times the base phase.
  logic signed [COS_W-1:0] cosv [NUM_TERMS];

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_lane
    csw_lane u_lane (
      .clk       (clk),
      .en        (en),
      .k         (3'(k)),
      .den       (den),
      .base      (base),
      .cos_value (cosv[k])
    );
  end

  // Weight each term, then sum through a registered tree.
  logic signed [PROD_W-1:0]  prod [NUM_TERMS];
  logic signed [PROD_W:0]    s4   [4];
  logic signed [PROD_W+1:0]  s2   [2];
  logic signed [ACC_W-1:0]   s1;
  logic signed [ACC_W-1:0]   rounded;

  assign rounded = s1 + (ACC_W'(1) <<< (ROUND_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      ep[0] <= {1'b0, sample_index} >= n_eff;
      for (int s = 1; s < VP_LEN; s++) ep[s] <= ep[s-1];
      base <= {sample_index, 1'b1};
      for (int k = 0; k < NUM_TERMS; k++)
        prod[k] <= PROD_W'(COEF_TAB[type_eff][k]) * PROD_W'(cosv[k]);
      for (int j = 0; j < 4; j++)
        s4[j] <= (PROD_W+1)'(prod[2*j]) + (PROD_W+1)'(prod[2*j+1]);
      for (int j = 0; j < 2; j++)
        s2[j] <= (PROD_W+2)'(s4[2*j]) + (PROD_W+2)'(s4[2*j+1]);
      s1 <= ACC_W'(s2[0]) + ACC_W'(s2[1]);
      // drop the value of an index past the window end
      window_value <= ep[VP_LEN-1] ? '0 : rounded[ROUND_SHIFT+OUT_W-1:ROUND_SHIFT];
      index_error  <= ep[VP_LEN-1];
    end
  end

endmodule

FILE: sim/cosine_sum_window_checker.sv
module cosine_sum_window_checker import csw_pkg::*; #(
  parameter logic [2:0] ADDR_TYPE = 3'd0,
  parameter logic [2:0] ADDR_LEN  = 3'd4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  input  logic                    sample_stall,
  input  logic [IDX_W-1:0]        sample_index,
  input  logic                    window_valid,
  input  logic                    window_stall,
  input  logic signed [OUT_W-1:0] window_value,
  input  logic                    index_error,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  input  logic                    pready,
  output int                      fail_count,
  output int                      pending_count
);

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    err;
  } weight_t;

  localparam longint unsigned ONE_Q30  = 64'd1 << 30;
  localparam longint unsigned QUART_PI = 64'd843314857;
  localparam longint unsigned BIAS     = 64'd1 << 62;

  localparam longint unsigned COS_STEP_DIV [6] = '{132, 90, 56, 30, 12, 2};
  localparam longint unsigned SIN_STEP_DIV [6] = '{156, 110, 72, 42, 20, 6};

  localparam longint WEIGHTS [6][8] = '{
    '{1745768471, 0, 0, 0, 0, 0, 0, 0},
    '{1073741824, -1073741824, 0, 0, 0, 0, 0, 0},
    '{1187116183, -1011247119, 0, 0, 0, 0, 0, 0},
    '{942202349, -1121669463, 179467114, 0, 0, 0, 0, 0},
    '{814990993, -1109273735, 320953112, -26534062, 0, 0, 0, 0},
    '{592339792, -966877045, 525598051, -190339619, 45909912, -7377050, 788768, -42810}
  };

  logic [TYPE_W-1:0] cur_type;
  logic [LEN_W-1:0]  cur_len;
  weight_t           weight_q[$];

  function automatic longint unsigned taylor(longint unsigned x, bit use_sin);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int j = 0; j < 6; j++)
      t = ONE_Q30 - (((x2 * t) >> 30) / (use_sin ? SIN_STEP_DIV[j] : COS_STEP_DIV[j]));
    return use_sin ? ((x * t) >> 30) : t;
  endfunction

  // cosine of m/den turns in Q30, folded by octant
  function automatic longint cos_of_turn(longint unsigned m, longint unsigned den);
    longint unsigned m8, oct, r, th, thc;
    m8  = m * 8;
    oct = (m8 / den) & 7;
    r   = m8 % den;
    th  = (r * QUART_PI) / den;
    thc = ((den - r) * QUART_PI) / den;
    case (oct)
      0: return  longint'(taylor(th, 1'b0));
      1: return  longint'(taylor(thc, 1'b1));
      2: return -longint'(taylor(th, 1'b1));
      3: return -longint'(taylor(thc, 1'b0));
      4: return -longint'(taylor(th, 1'b0));
      5: return -longint'(taylor(thc, 1'b1));
      6: return  longint'(taylor(th, 1'b1));
      default: return longint'(taylor(thc, 1'b0));
    endcase
  endfunction

  function automatic weight_t window_weight(logic [IDX_W-1:0] idx);
    weight_t         w;
    int              typ;
    longint unsigned n, den, base, u;
    longint          acc;
    typ = (cur_type > TYPE_GAUSS) ? TYPE_GAUSS : cur_type;
    n   = (cur_len > MAX_LENGTH) ? MAX_LENGTH : cur_len;
    if (idx >= n) begin
      w.value = '0;
      w.err   = 1'b1;
      return w;
    end
    den  = 2 * n;
    base = 2 * idx + 1;
    acc  = 0;
    for (int k = 0; k < 8; k++)
      acc += WEIGHTS[typ][k] * cos_of_turn((k * base) % den, den);
    u = longint'(acc) + BIAS;
    u += 64'd1 << (ROUND_SHIFT - 1);
    u >>= ROUND_SHIFT;
    u -= BIAS >> ROUND_SHIFT;
    w.value = u[OUT_W-1:0];
    w.err   = 1'b0;
    return w;
  endfunction

  always @(posedge clk) begin
    weight_t want;
    if (rst) begin
      cur_type      <= TYPE_GAUSS;
      cur_len       <= LEN_W'(256);
      fail_count    <= 0;
      weight_q.delete();
      pending_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_TYPE) cur_type <= pwdata[TYPE_W-1:0];
        else if (paddr == ADDR_LEN) cur_len <= pwdata[LEN_W-1:0];
      end
      if (sample_valid && !sample_stall)
        weight_q.push_back(window_weight(sample_index));
      if (window_valid && !window_stall) begin
        if (weight_q.size() == 0) begin
          $display("%0t: unexpected result value=%0d err=%0b", $time, window_value,
                   index_error);
          fail_count <= fail_count + 1;
        end else begin
          want = weight_q.pop_front();
          if (want.value !== window_value || want.err !== index_error) begin
            $display("%0t: mismatch expected value=%0d err=%0b actual value=%0d err=%0b",
                     $time, want.value, want.err, window_value, index_error);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= weight_q.size();
    end
  end

endmodule

FILE: sim/cosine_sum_window_generator_tb.sv
module cosine_sum_window_generator_tb;
  import csw_pkg::*;

  // register map: one 32-bit word per register
  localparam logic [2:0] ADDR_TYPE = 3'd0;
  localparam logic [2:0] ADDR_LEN  = 3'd4;

  typedef enum logic [2:0] {
    WT_RECT, WT_HANN, WT_HAMMING, WT_BLACKMAN, WT_BHARRIS, WT_GAUSS, WT_SPARE6, WT_SPARE7
  } win_type_e;

  localparam int NUM_PHASES  = 14;
  localparam int RAND_ITEMS  = 84;

  logic                    clk;
  logic                    rst;
  logic                    sample_valid;
  logic                    sample_stall;
  logic [IDX_W-1:0]        sample_index;
  logic                    window_valid;
  logic                    window_stall;
  logic signed [OUT_W-1:0] window_value;
  logic                    index_error;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [2:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;
  int                      fail_count;
  int                      pending_count;

  // the first phase runs on reset values; the rest sweep lengths and types,
  // including zero length, one, the maximum and values past it
  win_type_e phase_type [NUM_PHASES] = '{WT_GAUSS, WT_RECT, WT_HANN, WT_HAMMING,
    WT_BLACKMAN, WT_BHARRIS, WT_SPARE6, WT_SPARE7, WT_HANN, WT_BLACKMAN, WT_BHARRIS,
    WT_GAUSS, WT_RECT, WT_HAMMING};
  int phase_len [NUM_PHASES] = '{256, 1, 4096, 8191, 0, 2, 17, 1000, 4097, 3, 4095, 640,
    4096, 64};

  cosine_sum_window_generator uut (.*);

  cosine_sum_window_checker #(.ADDR_TYPE(ADDR_TYPE), .ADDR_LEN(ADDR_LEN)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly no gap, sometimes a few cycles, rarely a long pause
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one index and hold it until the transfer completes
  task automatic send_index(input logic [IDX_W-1:0] idx);
    int gap;
    sample_valid <= 1'b1;
    sample_index <= idx;
    #1;
    while (sample_stall) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    gap = gap_len();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      sample_index <= IDX_W'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // hold until every expected weight has arrived
  task automatic drain();
    sample_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  // receiver: stall in bursts of random length, with long clean stretches
  initial begin
    window_stall = 1'b0;
    @(negedge clk);
    forever begin
      window_stall <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(50, 200) : gap_len() + 1)
        @(negedge clk);
      window_stall <= 1'b1;
      repeat (gap_len() + 1) @(negedge clk);
    end
  end

  initial begin
    int n;
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample_index = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_reg(ADDR_TYPE, 32'(phase_type[p]));
        write_reg(ADDR_LEN, 32'(phase_len[p]));
      end
      n = (phase_len[p] > MAX_LENGTH) ? MAX_LENGTH : phase_len[p];
      // edges of the window: first, last, first out of range, top of the field; then the middle
      send_index('0);
      send_index(IDX_W'(n > 0 ? n - 1 : 0));
      send_index(IDX_W'(n));
      send_index({IDX_W{1'b1}});
      send_index(IDX_W'(n / 2));
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if (n > 0 && $urandom_range(0, 99) < 85)
          send_index(IDX_W'($urandom_range(0, n - 1)));
        else
          send_index(IDX_W'($urandom));
      end
    end

    drain();
    repeat (60) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
